>>> src/assert_macros.svh
// Assertion macros shared by the tiled-to-raster writer RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property holds at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> src/t2r_pkg.sv
// Shared types and constants for the tiled-to-raster writer.
// No dependencies; used by t2r_cfg_if, t2r_geom and the top level.
`timescale 1ns / 1ps

package t2r_pkg;

	localparam int TILE_BYTES     = 32;
	localparam int TILE_LINES     = 32;
	localparam int WORD_BYTES     = 8;
	localparam int WORDS_PER_LINE = TILE_BYTES / WORD_BYTES;
	localparam int OFFSET_W       = 24;
	localparam int WORD_W         = 64;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 13;

	localparam logic [WORD_W-1:0] LOW_BYTES = 64'h00FF_00FF_00FF_00FF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PICTURE_WIDTH  = 2'd0,
		REG_PICTURE_HEIGHT = 2'd1,
		REG_CHROMA_PLANE   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic                  write_enable;
		logic [OFFSET_W-1:0]   dest_offset;
		logic [WORD_W-1:0]     dest_word;
		logic                  frame_last;
	} t2r_result_t;

	// Swap the two bytes of every 16-bit pair (U,V -> V,U).
	function automatic logic [WORD_W-1:0] swap_pairs(input logic [WORD_W-1:0] x);
		swap_pairs = ((x >> 8) & LOW_BYTES) | ((x & LOW_BYTES) << 8);
	endfunction

endpackage

>>> src/t2r_if.sv
// Handshake interfaces of the tiled-to-raster writer: a generic word stream
// and the configuration write channel. Depends on t2r_pkg.
`timescale 1ns / 1ps

interface t2r_stream_if #(
	parameter type payload_t = logic [63:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface t2r_cfg_if ();
	import t2r_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/t2r_geom.sv
// Plane geometry from the size registers: line count, stride and tile counts.
// Purely combinational; depends on t2r_pkg.
`timescale 1ns / 1ps

module t2r_geom #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int DW         = 13,
	parameter int LW         = 13
) (
	input  logic [t2r_pkg::CFG_DATA_W-1:0] picture_width,
	input  logic [t2r_pkg::CFG_DATA_W-1:0] picture_height,
	input  logic                           chroma_plane,
	output logic [LW-1:0]                  lines,
	output logic [DW-1:0]                  stride,
	output logic [DW-6:0]                  cols,
	output logic [LW-6:0]                  rows
);
	import t2r_pkg::*;

	localparam int CW = CFG_DATA_W + 1;

	logic [DW-1:0] w;
	logic [LW-1:0] h;
	logic [DW-1:0] width_bytes;
	logic [DW-1:0] wb_tiles;
	logic [LW-1:0] ln_tiles;

	// Zero counts as one, oversize counts as the maximum.
	always_comb begin
		priority if (picture_width == '0) begin
			w = DW'(1);
		end else if (CW'(picture_width) > CW'(MAX_WIDTH)) begin
			w = DW'(MAX_WIDTH);
		end else begin
			w = DW'(picture_width);
		end
		priority if (picture_height == '0) begin
			h = LW'(1);
		end else if (CW'(picture_height) > CW'(MAX_HEIGHT)) begin
			h = LW'(MAX_HEIGHT);
		end else begin
			h = LW'(picture_height);
		end
	end

	always_comb begin
		if (chroma_plane) begin
			width_bytes = (w + DW'(1)) & ~DW'(1);
			lines       = LW'((h + LW'(1)) >> 1);
		end else begin
			width_bytes = w;
			lines       = h;
		end
		stride   = (width_bytes + DW'(15)) & ~DW'(15);
		wb_tiles = width_bytes + DW'(TILE_BYTES - 1);
		ln_tiles = lines + LW'(TILE_LINES - 1);
		cols     = wb_tiles[DW-1:5];
		rows     = ln_tiles[LW-1:5];
	end

endmodule

>>> src/tiled_yuv420_to_raster_writer.sv
// Tiled plane to raster writer. Source words (8 bytes of a 32x32-byte tile,
// tiles in row order, tile lines top to bottom, four words per line) enter on
// src; each gives exactly one result on dst in the next cycle: write_enable,
// plane byte offset, data (byte pairs swapped in chroma mode) and frame_last
// on the final word of the plane. One word per cycle sustained; the single
// output register stalls src only while dst holds back a result. The result
// path is one 12x13 multiply (line times stride) plus an add. Write cfg only
// while idle; src carries logic [63:0], dst carries t2r_pkg::t2r_result_t.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tiled_yuv420_to_raster_writer #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input logic         clk,
	input logic         arst_n,
	t2r_cfg_if.sink     cfg,
	t2r_stream_if.sink  src,
	t2r_stream_if.source dst
);
	import t2r_pkg::*;

	localparam int DW   = $clog2(MAX_WIDTH + 33);
	localparam int LW   = $clog2(MAX_HEIGHT + 33);
	localparam int TCR  = $clog2((MAX_WIDTH + TILE_BYTES - 1) / TILE_BYTES);
	localparam int TRR  = $clog2((MAX_HEIGHT + TILE_LINES - 1) / TILE_LINES);
	localparam int TCW  = (TCR < 1) ? 1 : TCR;
	localparam int TRW  = (TRR < 1) ? 1 : TRR;
	localparam int RW   = TRW + 5;
	localparam int CLW  = TCW + 5;
	localparam int RCW  = (RW > LW) ? RW : LW;
	localparam int CCW  = (CLW > DW) ? CLW : DW;
	localparam int TCC  = (TCW + 1 > DW - 5) ? TCW + 1 : DW - 5;
	localparam int TRC  = (TRW + 1 > LW - 5) ? TRW + 1 : LW - 5;
	localparam int PW   = RW + DW;

	// configuration registers
	logic [CFG_DATA_W-1:0] picture_width_q;
	logic [CFG_DATA_W-1:0] picture_height_q;
	logic                  chroma_plane_q;

	// position of the next source word
	logic [TRW-1:0] tile_row_q;
	logic [TCW-1:0] tile_column_q;
	logic [4:0]     line_in_tile_q;
	logic [1:0]     word_in_line_q;

	logic          out_valid_q;
	t2r_result_t   result_q;

	logic [LW-1:0]   lines;
	logic [DW-1:0]   stride;
	logic [DW-6:0]   cols;
	logic [LW-6:0]   rows;

	logic            src_fire;
	logic [RW-1:0]   row;
	logic [CLW-1:0]  col;
	logic            keep;
	logic            last_col;
	logic            last_row;
	logic            last_word;
	logic            line_end;
	logic            tile_end;
	logic [PW-1:0]   product;
	logic [PW:0]     offset_sum;
	logic [WORD_W-1:0] data_out;
	logic            clip_dirty;
	logic            pos_home;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			picture_width_q  <= CFG_DATA_W'(16);
			picture_height_q <= CFG_DATA_W'(16);
			chroma_plane_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_PICTURE_WIDTH:  picture_width_q  <= cfg.data;
				REG_PICTURE_HEIGHT: picture_height_q <= cfg.data;
				REG_CHROMA_PLANE:   chroma_plane_q   <= cfg.data[0];
				default:            ; // drop writes beyond the register list
			endcase
		end
	end

	t2r_geom #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.DW         (DW),
		.LW         (LW)
	) u_geom (
		.picture_width  (picture_width_q),
		.picture_height (picture_height_q),
		.chroma_plane   (chroma_plane_q),
		.lines          (lines),
		.stride         (stride),
		.cols           (cols),
		.rows           (rows)
	);

	assign src.ready = !out_valid_q || dst.ready;
	assign src_fire  = src.valid && src.ready;

	always_comb begin
		row        = {tile_row_q, line_in_tile_q};
		col        = {tile_column_q, word_in_line_q, 3'b000};
		keep       = (RCW'(row) < RCW'(lines)) && (CCW'(col) < CCW'(stride));
		last_col   = (TCC'(tile_column_q) + TCC'(1)) >= TCC'(cols);
		last_row   = (TRC'(tile_row_q) + TRC'(1)) >= TRC'(rows);
		line_end   = word_in_line_q == 2'(WORDS_PER_LINE - 1);
		tile_end   = line_end && (line_in_tile_q == 5'(TILE_LINES - 1));
		last_word  = tile_end && last_col && last_row;
		product    = PW'(row) * PW'(stride);
		offset_sum = (PW + 1)'(product) + (PW + 1)'(col);
		data_out   = chroma_plane_q ? swap_pairs(src.data) : src.data;
		clip_dirty = !result_q.write_enable &&
			(result_q.dest_offset != '0 || result_q.dest_word != '0);
		pos_home   = {tile_row_q, tile_column_q, line_in_tile_q, word_in_line_q} == '0;
	end

	// advance word, line, tile column, tile row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_row_q     <= '0;
			tile_column_q  <= '0;
			line_in_tile_q <= '0;
			word_in_line_q <= '0;
		end else if (src_fire) begin
			word_in_line_q <= word_in_line_q + 2'd1;
			if (line_end) begin
				line_in_tile_q <= line_in_tile_q + 5'd1;
			end
			if (tile_end) begin
				if (!last_col) begin
					tile_column_q <= tile_column_q + TCW'(1);
				end else begin
					tile_column_q <= '0;
					tile_row_q    <= last_row ? '0 : tile_row_q + TRW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (src.ready) begin
			out_valid_q <= src.valid;
		end
	end

	// hold the result while dst stalls
	always_ff @(posedge clk) begin
		if (src_fire) begin
			result_q.write_enable <= keep;
			result_q.dest_offset  <= keep ? OFFSET_W'(offset_sum) : '0;
			result_q.dest_word    <= keep ? data_out : '0;
			result_q.frame_last   <= last_word;
		end
	end

	assign dst.valid = out_valid_q;
	assign dst.data  = result_q;

	`ASSERT_NEVER(a_stall_hold, clk, arst_n, src_fire && out_valid_q && !dst.ready, "taken in stall")
	`ASSERT_NEVER(a_clip_zero, clk, arst_n, out_valid_q && clip_dirty, "clipped result not zero")
	`ASSERT_PROP(a_wrap_last, clk, arst_n, src_fire && last_word |=> pos_home, "position not home")
	`ASSERT_PROP(a_result_next, clk, arst_n, src_fire |=> out_valid_q, "word gave no result")

endmodule
